// ===== rtl/wsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsrd_pkg: shared types and constants of the range dispatcher
// Holds the configuration register indexes, fixed field widths and the
// sequencer state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wsrd_pkg;

    // Fixed field widths
    localparam int JOB_CNT_W  = 17;
    localparam int PART_CNT_W = 7;
    localparam int REQ_W      = 6;
    localparam int JOB_IDX_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    // Width used for small index compares (queue counts, requester, counters)
    localparam int IDX_CMP_W  = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_JOB_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'b1;

    // Item modes
    localparam logic MODE_SEED = 1'b0;
    localparam logic MODE_TAKE = 1'b1;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_SEED  = 6'b000100,
        ST_OWN   = 6'b001000,
        ST_SCAN  = 6'b010000,
        ST_STEAL = 6'b100000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/work_stealing_range_dispatcher.sv =====
// ----------------------------------------------------------------------------
// work_stealing_range_dispatcher: job range dispatcher with work stealing
// Seeds per-participant job queues from one range and hands out job indexes,
// popping the requester's own queue or stealing from the fullest peer.
// ----------------------------------------------------------------------------
// A cancelled item or a seed with no jobs gives its result in the cycle after the transfer.
// Seed: the restoring divider runs, then one slice is written a cycle, one per active queue.
// Take from own queue: the own queue is read while idle and popped; a steal scans the active
// peers (one queue read a cycle through the single queue memory read port). One item at a
// time; busy is high while an item is in work. The receiver cannot stall the result.
// Reset (synchronous, active low) clears the active and job counts, result and sequencer and
// sets the participant count to 1; queue memory is not cleared (only seeded queues are read).
// ----------------------------------------------------------------------------
`default_nettype none

module work_stealing_range_dispatcher #(
    parameter int QUEUES   = 64,
    parameter int MAX_JOBS = 65536
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // item command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_mode,
    input  wire logic [wsrd_pkg::REQ_W-1:0]        i_requester,
    input  wire logic                              i_cancel,
    // result strobe
    output logic                                   o_valid,
    output logic [wsrd_pkg::JOB_IDX_W-1:0]         o_job_index,
    output logic                                   o_granted,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [wsrd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [wsrd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import wsrd_pkg::*;

    // Queue bounds hold values 0..MAX_JOBS
    localparam int QW   = $clog2(MAX_JOBS + 1);
    // Width that holds both the job count register and MAX_JOBS
    localparam int CW   = (QW > JOB_CNT_W) ? QW : JOB_CNT_W;
    // Active queue count 0..QUEUES
    localparam int PW   = $clog2(QUEUES + 1);
    // Queue memory address
    localparam int QIW  = $clog2(QUEUES);
    // Shared counter: divider steps and queue sweeps
    localparam int CNTW = $clog2(((QW > QUEUES) ? QW : QUEUES) + 1);
    localparam int CMPW = IDX_CMP_W;

    typedef struct packed {
        logic [QW-1:0] front;
        logic [QW-1:0] tail;
    } t_entry;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                 r_state, n_state;
    logic [JOB_CNT_W-1:0]   r_job_count, n_job_count;
    logic [PART_CNT_W-1:0]  r_part_count, n_part_count;
    logic [PW-1:0]          r_active, n_active;

    logic [CNTW-1:0]        r_cnt, n_cnt;       // divider step / queue sweep index
    logic [QW-1:0]          r_quo, n_quo;       // dividend, then quotient (base)
    logic [PW-1:0]          r_rem, n_rem;       // partial remainder
    logic [PW-1:0]          r_div, n_div;       // clamped participant count
    logic [QW-1:0]          r_cursor, n_cursor; // next job index while seeding

    logic [REQ_W-1:0]       r_who, n_who;
    logic                   r_own_ok, n_own_ok;
    logic                   r_pend, n_pend;     // a scan read is in flight
    logic [QIW-1:0]         r_pend_idx, n_pend_idx;
    logic [QW-1:0]          r_best_cnt, n_best_cnt;
    logic [QIW-1:0]         r_best_idx, n_best_idx;
    t_entry                 r_best, n_best;

    logic                   r_out_vld, n_out_vld;
    logic [JOB_IDX_W-1:0]   r_out_job, n_out_job;
    logic                   r_out_grant, n_out_grant;

    // Queue memory: one write port, one registered read port
    t_entry                 r_mem [QUEUES];
    t_entry                 r_rd;
    logic                   w_we;
    logic [QIW-1:0]         w_waddr;
    t_entry                 w_wdata;
    logic [QIW-1:0]         w_raddr;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                   w_accept;
    logic [CW-1:0]          w_jobs_ext, w_jobs_sat;
    logic [CW-1:0]          w_parts_a, w_parts_b, w_parts_c;
    logic [PW:0]            w_trial, w_diff;
    logic                   w_ge;
    logic [QW-1:0]          w_len;
    logic [QW-1:0]          w_avail;
    logic                   w_issue;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_accept    = start && !busy;

    // Clamp the job count to MAX_JOBS and the participants to 1..QUEUES..jobs
    always_comb begin
        w_jobs_ext = CW'(r_job_count);
        w_jobs_sat = (w_jobs_ext > CW'(MAX_JOBS)) ? CW'(MAX_JOBS) : w_jobs_ext;
        w_parts_a  = (r_part_count == '0) ? CW'(1) : CW'(r_part_count);
        w_parts_b  = (w_parts_a > CW'(QUEUES)) ? CW'(QUEUES) : w_parts_a;
        w_parts_c  = (w_parts_b > w_jobs_sat) ? w_jobs_sat : w_parts_b;
    end

    // Restoring divider step: one quotient bit a cycle
    assign w_trial = {r_rem, r_quo[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    // Slice length of the queue being seeded
    assign w_len = r_quo + QW'(CMPW'(r_cnt) < CMPW'(r_rem));

    // Jobs left in the queue read back during the scan
    assign w_avail = (r_rd.tail > r_rd.front) ? (r_rd.tail - r_rd.front) : '0;

    assign w_issue = (CMPW'(r_cnt) < CMPW'(r_active));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_job_count  = r_job_count;
        n_part_count = r_part_count;
        n_active     = r_active;
        n_cnt        = r_cnt;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_div        = r_div;
        n_cursor     = r_cursor;
        n_who        = r_who;
        n_own_ok     = r_own_ok;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_best_cnt   = r_best_cnt;
        n_best_idx   = r_best_idx;
        n_best       = r_best;
        n_out_vld    = 1'b0;
        n_out_job    = '0;
        n_out_grant  = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_cnt[QIW-1:0];
        w_wdata      = r_rd;
        w_raddr      = r_cnt[QIW-1:0];

        // Configuration transfers, taken while idle
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_JOB_COUNT:  n_job_count  = i_cfg_data[JOB_CNT_W-1:0];
                CFG_PART_COUNT: n_part_count = i_cfg_data[PART_CNT_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                // Read the requester's queue now, so it is ready next cycle
                w_raddr = i_requester[QIW-1:0];
                if (w_accept) begin
                    n_who    = i_requester;
                    n_own_ok = (CMPW'(i_requester) < CMPW'(r_active));
                    if (i_cancel) begin
                        // Cancelled: grant nothing, leave queues alone
                        n_out_vld = 1'b1;
                    end else if (i_mode == MODE_SEED) begin
                        if (w_parts_c == '0) begin
                            // No jobs: every queue counts as empty
                            n_active  = '0;
                            n_out_vld = 1'b1;
                        end else begin
                            n_quo   = QW'(w_jobs_sat);
                            n_rem   = '0;
                            n_div   = PW'(w_parts_c);
                            n_cnt   = '0;
                            n_state = ST_DIV;
                        end
                    end else begin
                        n_state = ST_OWN;
                    end
                end
            end

            ST_DIV: begin
                n_rem = w_ge ? w_diff[PW-1:0] : w_trial[PW-1:0];
                n_quo = {r_quo[QW-2:0], w_ge};
                if (CMPW'(r_cnt) == CMPW'(QW - 1)) begin
                    n_cnt    = '0;
                    n_cursor = '0;
                    n_state  = ST_SEED;
                end else begin
                    n_cnt = r_cnt + CNTW'(1);
                end
            end

            ST_SEED: begin
                // Write one contiguous slice a cycle
                w_we          = 1'b1;
                w_waddr       = r_cnt[QIW-1:0];
                w_wdata.front = r_cursor;
                w_wdata.tail  = r_cursor + w_len;
                n_cursor      = r_cursor + w_len;
                n_cnt         = r_cnt + CNTW'(1);
                if (CMPW'(r_cnt) + CMPW'(1) == CMPW'(r_div)) begin
                    n_active  = r_div;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end

            ST_OWN: begin
                if (r_own_ok && (r_rd.front < r_rd.tail)) begin
                    // Pop the front of the own queue
                    w_we          = 1'b1;
                    w_waddr       = r_who[QIW-1:0];
                    w_wdata.front = r_rd.front + QW'(1);
                    w_wdata.tail  = r_rd.tail;
                    n_out_vld     = 1'b1;
                    n_out_job     = JOB_IDX_W'(r_rd.front);
                    n_out_grant   = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    n_cnt      = '0;
                    n_pend     = 1'b0;
                    n_best_cnt = '0;
                    n_state    = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Issue one peer read a cycle, compare the one that came back
                w_raddr    = r_cnt[QIW-1:0];
                n_pend     = w_issue;
                n_pend_idx = r_cnt[QIW-1:0];
                if (w_issue) begin
                    n_cnt = r_cnt + CNTW'(1);
                end
                if (r_pend && (CMPW'(r_pend_idx) != CMPW'(r_who))
                        && (w_avail > r_best_cnt)) begin
                    n_best_cnt = w_avail;
                    n_best_idx = r_pend_idx;
                    n_best     = r_rd;
                end
                if (!w_issue && !r_pend) begin
                    n_state = ST_STEAL;
                end
            end

            ST_STEAL: begin
                n_out_vld = 1'b1;
                if (r_best_cnt != '0) begin
                    // Take one job off the tail of the fullest peer
                    w_we          = 1'b1;
                    w_waddr       = r_best_idx;
                    w_wdata.front = r_best.front;
                    w_wdata.tail  = r_best.tail - QW'(1);
                    n_out_job     = JOB_IDX_W'(r_best.tail - QW'(1));
                    n_out_grant   = 1'b1;
                end
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_job_count  <= '0;
            r_part_count <= PART_CNT_W'(1);
            r_active     <= '0;
            r_pend       <= 1'b0;
            r_out_vld    <= 1'b0;
            r_out_grant  <= 1'b0;
            r_out_job    <= '0;
        end else begin
            r_state      <= n_state;
            r_job_count  <= n_job_count;
            r_part_count <= n_part_count;
            r_active     <= n_active;
            r_pend       <= n_pend;
            r_out_vld    <= n_out_vld;
            r_out_grant  <= n_out_grant;
            r_out_job    <= n_out_job;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_cursor   <= n_cursor;
        r_who      <= n_who;
        r_own_ok   <= n_own_ok;
        r_pend_idx <= n_pend_idx;
        r_best_cnt <= n_best_cnt;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
    end

    // Queue memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    assign o_valid     = r_out_vld;
    assign o_job_index = r_out_job;
    assign o_granted   = r_out_grant;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_strobe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_IDLE))
        else $error("result strobe while an item is still in work");

    a_grant_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_granted |-> o_valid)
        else $error("grant flag without result strobe");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted item neither in work nor finished");

    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_active) <= CMPW'(QUEUES))
        else $error("active queue count above queue capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CMPW'(r_cnt) <= CMPW'(r_active)))
        else $error("peer scan ran past the active queues");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the work stealing range dispatcher
// Seeds the participant queues under many job and participant counts, then
// sends take requests from owners, outsiders and cancelled dispatches. Each
// result is checked field by field against a cycle-free model of the queues.
// ----------------------------------------------------------------------------

module tb;

    import wsrd_pkg::*;

    localparam int QUEUES     = 64;
    localparam int MAX_JOBS   = 65536;
    localparam int ITEM_TOTAL = 1150;
    localparam int DIR_ROWS   = 24;

    // One result as the block presents it
    typedef struct packed {
        logic [JOB_IDX_W-1:0] job;
        logic                 granted;
    } t_grant;

    // One directed stimulus row; optional register setup ahead of the item
    typedef struct {
        logic            set_cfg;
        int unsigned     jobs;
        int unsigned     parts;
        logic            mode;
        logic [REQ_W-1:0] req;
        logic            cancel;
        logic            typed;
        logic [JOB_IDX_W-1:0] exp_job;
        logic            exp_granted;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_mode;
    logic [REQ_W-1:0]      i_requester;
    logic                  i_cancel;
    logic                  o_valid;
    logic [JOB_IDX_W-1:0]  o_job_index;
    logic                  o_granted;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    work_stealing_range_dispatcher #(
        .QUEUES   (QUEUES),
        .MAX_JOBS (MAX_JOBS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_requester (i_requester),
        .i_cancel    (i_cancel),
        .o_valid     (o_valid),
        .o_job_index (o_job_index),
        .o_granted   (o_granted),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // The slowest legal run stays well under a quarter of this
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Queue model: each queue holds jobs head..end-1
    // ------------------------------------------------------------------
    logic [JOB_CNT_W-1:0]  q_head [QUEUES];
    logic [JOB_CNT_W-1:0]  q_end  [QUEUES];
    int unsigned           n_active;
    logic [JOB_CNT_W-1:0]  reg_jobs;
    logic [PART_CNT_W-1:0] reg_parts;

    t_grant pending_grants[$];

    int n_errors;
    int n_items;
    int n_setups;
    int n_seeds;
    int n_own;
    int n_steal;
    int n_dry;
    int n_cancel;

    // Split the clamped job range into contiguous slices, clear the rest
    task automatic seed_queues_model();
        int unsigned jobs, parts, base, rem, cursor, len;
        jobs  = 32'(reg_jobs);
        parts = 32'(reg_parts);
        if (jobs > MAX_JOBS) jobs = MAX_JOBS;
        if (parts < 1) parts = 1;
        if (parts > QUEUES) parts = QUEUES;
        if (parts > jobs) parts = jobs;
        for (int q = 0; q < QUEUES; q++) begin
            q_head[q] = '0;
            q_end[q]  = '0;
        end
        n_active = parts;
        if (parts == 0) return;
        base   = jobs / parts;
        rem    = jobs % parts;
        cursor = 0;
        for (int q = 0; q < parts; q++) begin
            len       = base + ((q < rem) ? 1 : 0);
            q_head[q] = JOB_CNT_W'(cursor);
            q_end[q]  = JOB_CNT_W'(cursor + len);
            cursor    = cursor + len;
        end
    endtask

    // Work out the grant of one item and advance the queue model
    task automatic predict_dispatch(input logic mode, input logic [REQ_W-1:0] req,
                                    input logic cancel, output t_grant res);
        int unsigned best, best_cnt, avail;
        res = '0;
        if (cancel) begin
            n_cancel++;
            return;
        end
        if (mode == MODE_SEED) begin
            seed_queues_model();
            n_seeds++;
            return;
        end
        // Own queue first
        if (32'(req) < n_active && q_head[req] < q_end[req]) begin
            res.job     = q_head[req][JOB_IDX_W-1:0];
            res.granted = 1'b1;
            q_head[req] = q_head[req] + JOB_CNT_W'(1);
            n_own++;
            return;
        end
        // Steal from the tail of the first fullest peer
        best     = 0;
        best_cnt = 0;
        for (int v = 0; v < n_active; v++) begin
            if (v == int'(req)) continue;
            avail = (q_end[v] > q_head[v]) ? 32'(q_end[v] - q_head[v]) : 0;
            if (avail > best_cnt) begin
                best_cnt = avail;
                best     = v;
            end
        end
        if (best_cnt == 0) begin
            n_dry++;
            return;
        end
        q_end[best] = q_end[best] - JOB_CNT_W'(1);
        res.job     = q_end[best][JOB_IDX_W-1:0];
        res.granted = 1'b1;
        n_steal++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: the receiver never stalls, so take every strobe
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_valid) begin
            if (pending_grants.size() == 0) begin
                $error("result with nothing pending: job_index %0d granted %0b",
                       o_job_index, o_granted);
                n_errors++;
            end else begin
                want = pending_grants.pop_front();
                if (o_job_index !== want.job) begin
                    $error("job_index: expected %0d, got %0d", want.job, o_job_index);
                    n_errors++;
                end
                if (o_granted !== want.granted) begin
                    $error("granted: expected %0b, got %0b", want.granted, o_granted);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Item channel
    // ------------------------------------------------------------------
    // Present one item and hold it until the transfer; start stays high so a
    // back-to-back item can follow. The caller drops start when it idles.
    task automatic issue_item(input logic mode, input logic [REQ_W-1:0] req,
                              input logic cancel, input logic typed,
                              input t_grant typed_res);
        t_grant res;
        start       <= 1'b1;
        i_mode      <= mode;
        i_requester <= req;
        i_cancel    <= cancel;
        do @(posedge i_clk); while (busy);
        predict_dispatch(mode, req, cancel, res);
        pending_grants.push_back(typed ? typed_res : res);
        n_items++;
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Random sender gaps; short ones mostly, long ones to land mid-steal
    task automatic maybe_gap(input bit quiet);
        if (!quiet && $urandom_range(0, 99) < 34) begin
            if ($urandom_range(0, 3) == 0)
                hold_off($urandom_range(9, 90));
            else
                hold_off($urandom_range(1, 8));
        end
    endtask

    // Hold the sender until every pending grant has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration channel
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_JOB_COUNT)
            reg_jobs = data[JOB_CNT_W-1:0];
        else
            reg_parts = data[PART_CNT_W-1:0];
    endtask

    // Drain, then write both registers in random order with an optional gap
    task automatic setup_dispatch(input int unsigned jobs, input int unsigned parts);
        bit jobs_first;
        wait_drained();
        jobs_first = 1'($urandom_range(0, 1));
        write_reg(jobs_first ? CFG_JOB_COUNT : CFG_PART_COUNT,
                  CFG_DATA_W'(jobs_first ? jobs : parts));
        if ($urandom_range(0, 99) < 34) begin
            i_cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        write_reg(jobs_first ? CFG_PART_COUNT : CFG_JOB_COUNT,
                  CFG_DATA_W'(jobs_first ? parts : jobs));
        i_cfg_valid <= 1'b0;
        n_setups++;
    endtask

    // ------------------------------------------------------------------
    // Directed table: extremes, clamps, cancels, steals and empty takes
    // ------------------------------------------------------------------
    t_stim_row dir_rows [DIR_ROWS] = '{
        // nothing seeded since reset
        '{1'b0, 0, 0, MODE_TAKE, 6'd0, 1'b0, 1'b1, 16'd0, 1'b0},
        '{1'b0, 0, 0, MODE_TAKE, 6'd63, 1'b1, 1'b1, 16'd0, 1'b0},
        // ten jobs over three queues: 0..3, 4..6, 7..9
        '{1'b1, 10, 3, MODE_SEED, 6'd0, 1'b0, 1'b1, 16'd0, 1'b0},
        '{1'b0, 0, 0, MODE_TAKE, 6'd0, 1'b0, 1'b1, 16'd0, 1'b1},
        '{1'b0, 0, 0, MODE_TAKE, 6'd2, 1'b0, 1'b1, 16'd7, 1'b1},
        // outsider steals from the first fullest queue
        '{1'b0, 0, 0, MODE_TAKE, 6'd5, 1'b0, 1'b0, 16'd0, 1'b0},
        '{1'b0, 0, 0, MODE_TAKE, 6'd0, 1'b1, 1'b1, 16'd0, 1'b0},
        // cancelled seed must leave the queues alone
        '{1'b0, 0, 0, MODE_SEED, 6'd0, 1'b1, 1'b1, 16'd0, 1'b0},
        '{1'b0, 0, 0, MODE_TAKE, 6'd1, 1'b0, 1'b1, 16'd4, 1'b1},
        // zero jobs clears everything
        '{1'b1, 0, 1, MODE_SEED, 6'd0, 1'b0, 1'b1, 16'd0, 1'b0},
        '{1'b0, 0, 0, MODE_TAKE, 6'd0, 1'b0, 1'b1, 16'd0, 1'b0},
        // full range, participant count of zero acts as one
        '{1'b1, 65536, 0, MODE_SEED, 6'd0, 1'b0, 1'b1, 16'd0, 1'b0},
        '{1'b0, 0, 0, MODE_TAKE, 6'd0, 1'b0, 1'b1, 16'd0, 1'b1},
        '{1'b0, 0, 0, MODE_TAKE, 6'd1, 1'b0, 1'b1, 16'd65535, 1'b1},
        // both counts saturate: 64 queues of 1024 jobs
        '{1'b1, 131071, 127, MODE_SEED, 6'd0, 1'b0, 1'b1, 16'd0, 1'b0},
        '{1'b0, 0, 0, MODE_TAKE, 6'd63, 1'b0, 1'b1, 16'd64512, 1'b1},
        '{1'b0, 0, 0, MODE_TAKE, 6'd0, 1'b0, 1'b1, 16'd0, 1'b1},
        // participants clamp to the job count
        '{1'b1, 2, 64, MODE_SEED, 6'd0, 1'b0, 1'b1, 16'd0, 1'b0},
        '{1'b0, 0, 0, MODE_TAKE, 6'd1, 1'b0, 1'b1, 16'd1, 1'b1},
        '{1'b0, 0, 0, MODE_TAKE, 6'd1, 1'b0, 1'b0, 16'd0, 1'b0},
        '{1'b0, 0, 0, MODE_TAKE, 6'd0, 1'b0, 1'b1, 16'd0, 1'b0},
        // single job, taken by an outsider, then nothing left
        '{1'b1, 1, 1, MODE_SEED, 6'd0, 1'b0, 1'b1, 16'd0, 1'b0},
        '{1'b0, 0, 0, MODE_TAKE, 6'd40, 1'b0, 1'b1, 16'd0, 1'b1},
        '{1'b0, 0, 0, MODE_TAKE, 6'd40, 1'b0, 1'b1, 16'd0, 1'b0}
    };

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned jobs, parts, burst, pick;
        logic [REQ_W-1:0] req;
        bit quiet;
        int spin;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_mode      <= MODE_SEED;
        i_requester <= '0;
        i_cancel    <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_JOB_COUNT;
        i_cfg_data  <= '0;

        // Model state after reset
        reg_jobs  = '0;
        reg_parts = PART_CNT_W'(1);
        n_active  = 0;
        for (int q = 0; q < QUEUES; q++) begin
            q_head[q] = '0;
            q_end[q]  = '0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].set_cfg)
                setup_dispatch(dir_rows[r].jobs, dir_rows[r].parts);
            else
                maybe_gap(1'b0);
            issue_item(dir_rows[r].mode, dir_rows[r].req, dir_rows[r].cancel,
                       dir_rows[r].typed, {dir_rows[r].exp_job, dir_rows[r].exp_granted});
        end

        // Random part: each setup seeds, then mostly live takes with random
        // requesters; cancels, reseeds and cancelled seeds are the noise
        while (n_items < ITEM_TOTAL) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      jobs = $urandom_range(0, 40);
            else if (pick < 85) jobs = $urandom_range(41, 3000);
            else if (pick < 95) jobs = $urandom_range(3001, MAX_JOBS);
            else                jobs = $urandom_range(MAX_JOBS + 1, 131071);
            pick = $urandom_range(0, 99);
            if (pick < 70)      parts = $urandom_range(1, QUEUES);
            else if (pick < 80) parts = 0;
            else if (pick < 90) parts = $urandom_range(QUEUES + 1, 127);
            else                parts = QUEUES;
            setup_dispatch(jobs, parts);

            issue_item(MODE_SEED, REQ_W'($urandom_range(0, 63)), 1'b0, 1'b0, '0);
            burst = $urandom_range(20, 60);
            for (int k = 0; k < burst && n_items < ITEM_TOTAL; k++) begin
                // Keep a long back-to-back stretch free of sender gaps
                quiet = (n_items >= 450 && n_items < 650);
                maybe_gap(quiet);
                if (!quiet && $urandom_range(0, 99) < 5)
                    wait_drained();
                if (n_active > 0 && $urandom_range(0, 99) < 70)
                    req = REQ_W'($urandom_range(0, n_active - 1));
                else
                    req = REQ_W'($urandom_range(0, 63));
                pick = $urandom_range(0, 99);
                if (pick < 80)      issue_item(MODE_TAKE, req, 1'b0, 1'b0, '0);
                else if (pick < 88) issue_item(MODE_TAKE, req, 1'b1, 1'b0, '0);
                else if (pick < 95) issue_item(MODE_SEED, req, 1'b1, 1'b0, '0);
                else                issue_item(MODE_SEED, req, 1'b0, 1'b0, '0);
            end
        end

        // Drop start and let the last grants come back, with a bound
        start <= 1'b0;
        spin = 0;
        while (pending_grants.size() != 0 && spin < 20000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (100) @(posedge i_clk);
        if (pending_grants.size() != 0) begin
            $error("%0d expected results never arrived", pending_grants.size());
            n_errors++;
        end

        $display("Ran %0d items over %0d register setups: %0d seeds, %0d cancelled.",
                 n_items, n_setups, n_seeds, n_cancel);
        $display("Takes: %0d from own queue, %0d stolen, %0d found nothing left.",
                 n_own, n_steal, n_dry);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
